// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL file serial_bank_mapper.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while out of reset.
`define SMB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SMB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/smb_pkg.sv =====
// Package for the serial bank mapper: transaction types and register map.
package smb_pkg;

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  data;
	} cpu_t;

	typedef struct packed {
		logic [5:0] prg_page_low;
		logic [5:0] prg_page_high;
		logic [6:0] chr_page_low;
		logic [6:0] chr_page_high;
		logic       chr_full_window;
		logic [1:0] mirroring;
		logic       ram_enabled;
		logic       ram_write;
	} map_t;

	localparam int unsigned PADDR_W = 4;

	localparam logic [1:0] REG_PRG_BANK_COUNT = 2'd0;
	localparam logic [1:0] REG_CHR_BANK_COUNT = 2'd1;
	localparam logic [1:0] REG_RAM_PRESENT    = 2'd2;
	localparam logic [1:0] REG_LARGE_PRG      = 2'd3;

	localparam logic [5:0] PRG_BANK_COUNT_RST = 6'd8;
	localparam logic [4:0] CHR_BANK_COUNT_RST = 5'd0;
	localparam logic       RAM_PRESENT_RST    = 1'b1;
	localparam logic       LARGE_PRG_RST      = 1'b0;

	// 2 * PRG_BANK_COUNT_RST - 2, the last 8KB page pair at reset
	localparam logic [5:0] PRG_HIGH_PAGE_RST  = 6'd14;
	localparam logic [6:0] CHR_HIGH_PAGE_RST  = 7'd4;

endpackage

// ===== sv/serial_bank_mapper.sv =====
// Serial bank mapper: input register, single-pass mapping update, result register.
// A transaction accepted into the input register moves on to map through the
// result register. Throughput: one transaction per cycle unless map_stall holds;
// the registers let a new write enter while a finished result waits on map_stall.
// Reset: all mapping state cleared, PRG 0xC000 page at the last bank of the
// reset bank count, CHR 0x1000 window at page 4, configuration at its defaults.
`include "assert_macros.svh"

module serial_bank_mapper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [smb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         cpu_valid,
	output logic                         cpu_stall,
	input  smb_pkg::cpu_t                cpu,
	output logic                         map_valid,
	input  logic                         map_stall,
	output smb_pkg::map_t                map
);

	typedef enum logic [2:0] {
		RGN_LOW,
		RGN_RAM,
		RGN_CTRL,
		RGN_CHR0,
		RGN_CHR1,
		RGN_PRG
	} region_t;

	// configuration
	logic [5:0] prg_bank_count_q;
	logic [4:0] chr_bank_count_q;
	logic       ram_present_q;
	logic       large_prg_q;

	// pipeline
	logic          valid_s1;
	smb_pkg::cpu_t cpu_s1;
	logic          map_valid_q;
	smb_pkg::map_t map_q;
	logic          take;

	// mapping state
	logic [4:0] shift_bits_q, shift_bits_d;
	logic [2:0] shift_count_q, shift_count_d;
	logic [1:0] mirror_q, mirror_d;
	logic [1:0] prg_mode_q, prg_mode_d;
	logic       chr_mode_q, chr_mode_d;
	logic [5:0] prg_low_q, prg_low_d;
	logic [5:0] prg_high_q, prg_high_d;
	logic [6:0] chr_low_q, chr_low_d;
	logic [6:0] chr_high_q, chr_high_d;
	logic       ram_off_q, ram_off_d;
	smb_pkg::map_t map_d;

	region_t    region;
	logic [4:0] bits_new;
	logic [4:0] val;
	logic       ctrl_we;
	logic [4:0] ctrl_v;
	logic [5:0] prg_cnt_m1;
	logic [3:0] prg_mask;
	logic [5:0] chr_cnt_m1;
	logic [4:0] chr_mask;
	logic [4:0] chr_val;
	logic [3:0] prg_bank;
	logic       half;
	logic       ram_wr;
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q <= smb_pkg::PRG_BANK_COUNT_RST;
			chr_bank_count_q <= smb_pkg::CHR_BANK_COUNT_RST;
			ram_present_q    <= smb_pkg::RAM_PRESENT_RST;
			large_prg_q      <= smb_pkg::LARGE_PRG_RST;
		end else if (cfg_we) begin
			case (paddr[3:2])
				smb_pkg::REG_PRG_BANK_COUNT: prg_bank_count_q <= pwdata[5:0];
				smb_pkg::REG_CHR_BANK_COUNT: chr_bank_count_q <= pwdata[4:0];
				smb_pkg::REG_RAM_PRESENT:    ram_present_q    <= pwdata[0];
				smb_pkg::REG_LARGE_PRG:      large_prg_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			smb_pkg::REG_PRG_BANK_COUNT: prdata = {26'd0, prg_bank_count_q};
			smb_pkg::REG_CHR_BANK_COUNT: prdata = {27'd0, chr_bank_count_q};
			smb_pkg::REG_RAM_PRESENT:    prdata = {31'd0, ram_present_q};
			smb_pkg::REG_LARGE_PRG:      prdata = {31'd0, large_prg_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// handshake
	assign take      = !map_valid_q || !map_stall;
	assign cpu_stall = valid_s1 && !take;
	assign map_valid = map_valid_q;
	assign map       = map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cpu_stall) begin
			valid_s1 <= cpu_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cpu_valid && !cpu_stall) begin
			cpu_s1 <= cpu;
		end
	end

	// mapping update
	always_comb begin
		case (cpu_s1.address[15:13])
			3'b011:  region = RGN_RAM;
			3'b100:  region = RGN_CTRL;
			3'b101:  region = RGN_CHR0;
			3'b110:  region = RGN_CHR1;
			3'b111:  region = RGN_PRG;
			default: region = RGN_LOW;
		endcase

		bits_new   = shift_bits_q | ({4'd0, cpu_s1.data[0]} << shift_count_q);
		val        = bits_new;
		prg_cnt_m1 = prg_bank_count_q - 6'd1;
		prg_mask   = prg_cnt_m1[3:0];
		chr_cnt_m1 = {chr_bank_count_q, 1'b0} - 6'd1;
		chr_mask   = chr_cnt_m1[4:0];
		chr_val    = val & chr_mask;
		prg_bank   = val[3:0] & prg_mask;
		half       = large_prg_q & prg_low_q[5];

		shift_bits_d  = shift_bits_q;
		shift_count_d = shift_count_q;
		mirror_d      = mirror_q;
		prg_mode_d    = prg_mode_q;
		chr_mode_d    = chr_mode_q;
		prg_low_d     = prg_low_q;
		prg_high_d    = prg_high_q;
		chr_low_d     = chr_low_q;
		chr_high_d    = chr_high_q;
		ram_off_d     = ram_off_q;
		ram_wr        = 1'b0;
		ctrl_we       = 1'b0;
		ctrl_v        = val;

		if (region == RGN_RAM) begin
			ram_wr = ram_present_q & ~ram_off_q;
		end else if (region != RGN_LOW) begin
			if (cpu_s1.data[7]) begin
				shift_bits_d  = 5'd0;
				shift_count_d = 3'd0;
				ctrl_we       = 1'b1;
				ctrl_v        = {chr_mode_q, 2'b11, mirror_q};
			end else if (shift_count_q != 3'd4) begin
				shift_bits_d  = bits_new;
				shift_count_d = shift_count_q + 3'd1;
			end else begin
				shift_bits_d  = 5'd0;
				shift_count_d = 3'd0;
				case (region)
					RGN_CTRL: begin
						ctrl_we = 1'b1;
					end
					RGN_CHR0: begin
						if (large_prg_q) begin
							prg_low_d[5]  = val[4];
							prg_high_d[5] = val[4];
						end
						if (chr_bank_count_q != 5'd0) begin
							if (chr_mode_q) begin
								chr_low_d = {chr_val, 2'b00};
							end else begin
								chr_low_d  = {chr_val[4:1], 3'b000};
								chr_high_d = {chr_val[4:1], 3'b100};
							end
						end
					end
					RGN_CHR1: begin
						if (large_prg_q && chr_mode_q) begin
							prg_low_d[5]  = val[4];
							prg_high_d[5] = val[4];
						end
						if (chr_bank_count_q != 5'd0 && chr_mode_q) begin
							chr_high_d = {chr_val, 2'b00};
						end
					end
					RGN_PRG: begin
						ram_off_d = val[4];
						if (!prg_mode_q[1]) begin
							prg_low_d  = {half, prg_bank[3:1], 2'b00};
							prg_high_d = {half, prg_bank[3:1], 2'b10};
						end else if (prg_mode_q == 2'd2) begin
							prg_high_d = {half, prg_bank, 1'b0};
						end else begin
							prg_low_d = {half, prg_bank, 1'b0};
						end
					end
					default: ;
				endcase
			end
		end

		// control register write: mirroring, PRG mode with page fix-up, CHR mode
		if (ctrl_we) begin
			mirror_d   = ctrl_v[1:0];
			chr_mode_d = ctrl_v[4];
			if (ctrl_v[3:2] != prg_mode_q) begin
				prg_mode_d = ctrl_v[3:2];
				if (ctrl_v[3:2] == 2'd2) begin
					prg_low_d = {prg_low_q[5], 5'd0};
				end else if (ctrl_v[3:2] == 2'd3) begin
					prg_high_d = {prg_low_q[5], prg_mask, 1'b0};
				end
			end
		end

		map_d.prg_page_low    = prg_low_d;
		map_d.prg_page_high   = prg_high_d;
		map_d.chr_page_low    = chr_low_d;
		map_d.chr_page_high   = chr_high_d;
		map_d.chr_full_window = ~chr_mode_d;
		map_d.mirroring       = mirror_d;
		map_d.ram_enabled     = ram_present_q & ~ram_off_d;
		map_d.ram_write       = ram_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q   <= 1'b0;
			shift_bits_q  <= 5'd0;
			shift_count_q <= 3'd0;
			mirror_q      <= 2'd0;
			prg_mode_q    <= 2'd0;
			chr_mode_q    <= 1'b0;
			prg_low_q     <= 6'd0;
			prg_high_q    <= smb_pkg::PRG_HIGH_PAGE_RST;
			chr_low_q     <= 7'd0;
			chr_high_q    <= smb_pkg::CHR_HIGH_PAGE_RST;
			ram_off_q     <= 1'b0;
		end else if (take) begin
			map_valid_q <= valid_s1;
			if (valid_s1) begin
				shift_bits_q  <= shift_bits_d;
				shift_count_q <= shift_count_d;
				mirror_q      <= mirror_d;
				prg_mode_q    <= prg_mode_d;
				chr_mode_q    <= chr_mode_d;
				prg_low_q     <= prg_low_d;
				prg_high_q    <= prg_high_d;
				chr_low_q     <= chr_low_d;
				chr_high_q    <= chr_high_d;
				ram_off_q     <= ram_off_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			map_q <= map_d;
		end
	end

	`SMB_ASSERT(a_shift_count_range, shift_count_q < 3'd5, "shift count past five")
	`SMB_ASSERT(a_stage_to_result, (valid_s1 && take) |=> map_valid, "transaction lost between stages")
	`SMB_ASSERT(a_ram_write_enabled, map_valid |-> (!map.ram_write || map.ram_enabled), "RAM strobe while RAM disabled")
	`SMB_ASSERT(a_chr_page_aligned, map_valid |-> (map.chr_page_low[1:0] == 2'd0), "CHR page not 4KB aligned")
	`SMB_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !map_valid || arst_n, "result valid out of reset")

endmodule

// ===== bench/serial_bank_mapper_tb.sv =====
// Self-checking bench for serial_bank_mapper: directed table, then random CPU write phases.
`timescale 1ns / 100ps

module serial_bank_mapper_tb;

	localparam logic [15:0] RAM_BASE    = 16'h6000;
	localparam logic [15:0] SERIAL_BASE = 16'h8000;
	localparam logic [15:0] CHR0_BASE   = 16'hA000;
	localparam logic [15:0] CHR1_BASE   = 16'hC000;
	localparam logic [15:0] PRG_BASE    = 16'hE000;
	localparam logic [7:0]  CLEAR_BIT   = 8'h80;
	localparam int          HOLD_CYCLES = 90;

	typedef struct packed {
		smb_pkg::cpu_t w;
		logic          typed;
		smb_pkg::map_t want;
	} directed_row_t;

	localparam smb_pkg::map_t NO_MAP = '0;
	localparam smb_pkg::map_t MAP_AT_RESET = '{
		prg_page_low: 6'd0, prg_page_high: smb_pkg::PRG_HIGH_PAGE_RST,
		chr_page_low: 7'd0, chr_page_high: smb_pkg::CHR_HIGH_PAGE_RST,
		chr_full_window: 1'b1, mirroring: 2'd0, ram_enabled: 1'b1, ram_write: 1'b0};
	localparam smb_pkg::map_t MAP_RAM_STORE = '{
		prg_page_low: 6'd0, prg_page_high: smb_pkg::PRG_HIGH_PAGE_RST,
		chr_page_low: 7'd0, chr_page_high: smb_pkg::CHR_HIGH_PAGE_RST,
		chr_full_window: 1'b1, mirroring: 2'd0, ram_enabled: 1'b1, ram_write: 1'b1};

	// low writes, RAM strobes, clear writes, one full load of each register, then a RAM write
	localparam directed_row_t DIRECTED [27] = '{
		'{'{16'h0000, 8'h00}, 1'b1, MAP_AT_RESET},
		'{'{16'h5FFF, 8'hFF}, 1'b1, MAP_AT_RESET},
		'{'{16'h6000, 8'h00}, 1'b1, MAP_RAM_STORE},
		'{'{16'h7FFF, 8'hFF}, 1'b1, MAP_RAM_STORE},
		'{'{16'h8000, 8'h80}, 1'b1, MAP_AT_RESET},
		'{'{16'hFFFF, 8'hFF}, 1'b1, MAP_AT_RESET},
		'{'{16'h8000, 8'h7E}, 1'b0, NO_MAP},
		'{'{16'h9FFF, 8'h01}, 1'b0, NO_MAP},
		'{'{16'h8000, 8'h00}, 1'b0, NO_MAP},
		'{'{16'h8000, 8'h7E}, 1'b0, NO_MAP},
		'{'{16'h9FFF, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hA000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hA000, 8'h7F}, 1'b0, NO_MAP},
		'{'{16'hA000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hA000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hBFFF, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hC000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hC000, 8'h00}, 1'b0, NO_MAP},
		'{'{16'hC000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hC000, 8'h40}, 1'b0, NO_MAP},
		'{'{16'hDFFF, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hE000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hE000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hE000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hE000, 8'h01}, 1'b0, NO_MAP},
		'{'{16'hFFFF, 8'h7F}, 1'b0, NO_MAP},
		'{'{16'h6000, 8'h00}, 1'b0, NO_MAP}
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [smb_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        cpu_valid = 1'b0;
	logic                        cpu_stall;
	smb_pkg::cpu_t               cpu = '0;
	logic                        map_valid;
	logic                        map_stall = 1'b0;
	smb_pkg::map_t               map;

	// shadow configuration
	logic [5:0] cfg_prg_banks  = smb_pkg::PRG_BANK_COUNT_RST;
	logic [4:0] cfg_chr_banks  = smb_pkg::CHR_BANK_COUNT_RST;
	logic       cfg_ram_fitted = smb_pkg::RAM_PRESENT_RST;
	logic       cfg_large      = smb_pkg::LARGE_PRG_RST;

	// shadow mapper state
	logic [4:0] sr_bits    = '0;
	logic [2:0] sr_count   = '0;
	logic [1:0] p_mirror   = '0;
	logic [1:0] p_prg_mode = '0;
	logic       p_chr_mode = 1'b0;
	logic [5:0] p_prg_lo   = '0;
	logic [5:0] p_prg_hi   = smb_pkg::PRG_HIGH_PAGE_RST;
	logic [6:0] p_chr_lo   = '0;
	logic [6:0] p_chr_hi   = smb_pkg::CHR_HIGH_PAGE_RST;
	logic       p_ram_off  = 1'b0;

	smb_pkg::map_t pending_maps [$];
	int   src_idle = 33;
	int   sink_idle = 33;
	int   writes_sent = 0;
	int   maps_checked = 0;
	int   mismatches = 0;
	int   settings_used = 1;

	serial_bank_mapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cpu_valid (cpu_valid),
		.cpu_stall (cpu_stall),
		.cpu       (cpu),
		.map_valid (map_valid),
		.map_stall (map_stall),
		.map       (map)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [3:0] prg_mask();
		logic [5:0] t;
		t = cfg_prg_banks - 6'd1;
		return t[3:0];
	endfunction

	task automatic set_control(input logic [4:0] v);
		logic [1:0] m;
		m = v[3:2];
		p_mirror = v[1:0];
		if (m != p_prg_mode) begin
			p_prg_mode = m;
			if (m == 2'd2)
				p_prg_lo = p_prg_lo & 6'h20;
			else if (m == 2'd3)
				p_prg_hi = {1'b0, prg_mask(), 1'b0} + {p_prg_lo[5], 5'b0};
		end
		p_chr_mode = v[4];
	endtask

	task automatic commit_serial(input logic [15:0] a, input logic [4:0] v);
		logic [5:0] cmask;
		logic [5:0] c;
		logic [3:0] b;
		logic       hb;
		cmask = {cfg_chr_banks, 1'b0} - 6'd1;
		c = {1'b0, v} & cmask;
		// 512KB board: CHR write also latches the PRG half
		if (cfg_large && a >= CHR0_BASE && a < PRG_BASE && (a < CHR1_BASE || p_chr_mode)) begin
			p_prg_lo[5] = v[4];
			p_prg_hi[5] = v[4];
		end
		if (a < CHR0_BASE) begin
			set_control(v);
		end else if (a < CHR1_BASE) begin
			if (cfg_chr_banks != 5'd0) begin
				if (p_chr_mode) begin
					p_chr_lo = 7'({c, 2'b00});
				end else begin
					p_chr_lo = 7'({c[5:1], 3'b000});
					p_chr_hi = p_chr_lo + 7'd4;
				end
			end
		end else if (a < PRG_BASE) begin
			if (cfg_chr_banks != 5'd0 && p_chr_mode)
				p_chr_hi = 7'({c, 2'b00});
		end else begin
			hb = cfg_large & p_prg_lo[5];
			b = v[3:0] & prg_mask();
			p_ram_off = v[4];
			if (p_prg_mode < 2'd2) begin
				p_prg_lo = {hb, b[3:1], 2'b00};
				p_prg_hi = p_prg_lo + 6'd2;
			end else if (p_prg_mode == 2'd2) begin
				p_prg_hi = {hb, b, 1'b0};
			end else begin
				p_prg_lo = {hb, b, 1'b0};
			end
		end
	endtask

	task automatic apply_cpu_write(input smb_pkg::cpu_t w, output smb_pkg::map_t m);
		logic       ram_on;
		logic       strobe;
		logic [4:0] v;
		ram_on = cfg_ram_fitted & ~p_ram_off;
		strobe = 1'b0;
		if (w.address >= RAM_BASE && w.address < SERIAL_BASE) begin
			strobe = ram_on;
		end else if (w.address >= SERIAL_BASE) begin
			if (w.data[7]) begin
				sr_bits = '0;
				sr_count = '0;
				set_control({p_chr_mode, 2'b11, p_mirror});
			end else begin
				sr_bits = sr_bits | (5'(w.data[0]) << sr_count);
				sr_count = sr_count + 3'd1;
				if (sr_count >= 3'd5) begin
					v = sr_bits;
					sr_bits = '0;
					sr_count = '0;
					commit_serial(w.address, v);
				end
			end
			ram_on = cfg_ram_fitted & ~p_ram_off;
		end
		m.prg_page_low    = p_prg_lo;
		m.prg_page_high   = p_prg_hi;
		m.chr_page_low    = p_chr_lo;
		m.chr_page_high   = p_chr_hi;
		m.chr_full_window = ~p_chr_mode;
		m.mirroring       = p_mirror;
		m.ram_enabled     = ram_on;
		m.ram_write       = strobe;
	endtask

	task automatic send_write(input smb_pkg::cpu_t w, input logic typed,
			input smb_pkg::map_t want);
		smb_pkg::map_t m;
		while ($urandom_range(99) < src_idle) begin
			cpu_valid <= 1'b0;
			@(posedge clk);
		end
		cpu_valid <= 1'b1;
		cpu <= w;
		do @(posedge clk); while (cpu_stall);
		apply_cpu_write(w, m);
		pending_maps.push_back(typed ? want : m);
		writes_sent++;
	endtask

	task automatic random_burst();
		smb_pkg::cpu_t w;
		int   r;
		int   k;
		r = $urandom_range(99);
		if (r < 75) begin
			// full five-bit load, or a short one broken off by a clear
			k = (r < 65) ? 5 : $urandom_range(4, 1);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(9) == 0) begin
					w.address = 16'($urandom_range(16'h7FFF));
					w.data = 8'($urandom);
					send_write(w, 1'b0, NO_MAP);
				end
				w.address = SERIAL_BASE | {1'b0, 2'($urandom_range(3)), 13'($urandom)};
				w.data = {1'b0, 7'($urandom)};
				send_write(w, 1'b0, NO_MAP);
			end
			if (k < 5) begin
				w.address = SERIAL_BASE | 16'($urandom_range(16'h7FFF));
				w.data = 8'($urandom) | CLEAR_BIT;
				send_write(w, 1'b0, NO_MAP);
			end
		end else if (r < 88) begin
			w.address = 16'($urandom_range(16'h7FFF));
			w.data = 8'($urandom);
			send_write(w, 1'b0, NO_MAP);
		end else begin
			w.address = 16'($urandom);
			w.data = 8'($urandom);
			send_write(w, 1'b0, NO_MAP);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			smb_pkg::REG_PRG_BANK_COUNT: cfg_prg_banks = val[5:0];
			smb_pkg::REG_CHR_BANK_COUNT: cfg_chr_banks = val[4:0];
			smb_pkg::REG_RAM_PRESENT:    cfg_ram_fitted = val[0];
			smb_pkg::REG_LARGE_PRG:      cfg_large = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [5:0] prg, input logic [4:0] chr, input logic ram,
			input logic big, input int n, input int idle);
		int start;
		cpu_valid <= 1'b0;
		while (pending_maps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(smb_pkg::REG_PRG_BANK_COUNT, 32'(prg));
		write_reg(smb_pkg::REG_CHR_BANK_COUNT, 32'(chr));
		write_reg(smb_pkg::REG_RAM_PRESENT, 32'(ram));
		write_reg(smb_pkg::REG_LARGE_PRG, 32'(big));
		src_idle = idle;
		sink_idle = idle;
		settings_used++;
		start = writes_sent;
		while (writes_sent - start < n) random_burst();
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic check_map();
		smb_pkg::map_t want;
		if (pending_maps.size() == 0) begin
			$display("%0t: unexpected mapping transaction, expected none got %h", $time, map);
			mismatches++;
		end else begin
			want = pending_maps.pop_front();
			maps_checked++;
			check_field("prg_page_low", 8'(want.prg_page_low), 8'(map.prg_page_low));
			check_field("prg_page_high", 8'(want.prg_page_high), 8'(map.prg_page_high));
			check_field("chr_page_low", 8'(want.chr_page_low), 8'(map.chr_page_low));
			check_field("chr_page_high", 8'(want.chr_page_high), 8'(map.chr_page_high));
			check_field("chr_full_window", 8'(want.chr_full_window), 8'(map.chr_full_window));
			check_field("mirroring", 8'(want.mirroring), 8'(map.mirroring));
			check_field("ram_enabled", 8'(want.ram_enabled), 8'(map.ram_enabled));
			check_field("ram_write", 8'(want.ram_write), 8'(map.ram_write));
		end
	endtask

	// result side: random stalls, plus two long hold-offs to back the block up
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && map_valid && !map_stall) begin
				check_map();
				if (maps_checked == 300 || maps_checked == 900)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				map_stall <= 1'b1;
				hold_left--;
			end else begin
				map_stall <= ($urandom_range(99) < sink_idle);
			end
		end
	end

	initial begin
		#200000;
		$display("serial_bank_mapper_tb: errors");
		$finish;
	end

	initial begin
		logic [4:0] chr_pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_write(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].want);
		run_phase(6'd2, 5'd0, 1'b0, 1'b0, 200, 33);
		run_phase(6'd32, 5'd16, 1'b1, 1'b1, 200, 33);
		run_phase(6'd16, 5'd1, 1'b1, 1'b1, 200, 0);
		run_phase(6'd4, 5'd8, 1'b0, 1'b1, 200, 33);
		run_phase(6'd8, 5'd2, 1'b1, 1'b0, 200, 33);
		chr_pick = ($urandom_range(5) == 0) ? 5'd0 : (5'd1 << $urandom_range(4));
		run_phase(6'd1 << $urandom_range(5, 1), chr_pick, 1'($urandom), 1'($urandom), 200, 33);
		cpu_valid <= 1'b0;
		while (pending_maps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d CPU write transactions over %0d mapper settings, %0d mappings compared",
			writes_sent, settings_used, maps_checked);
		$display("covered serial loads of all four registers, clears, RAM strobes and back-pressure");
		if (mismatches == 0)
			$display("serial_bank_mapper_tb: clean");
		else
			$display("serial_bank_mapper_tb: errors");
		$finish;
	end

endmodule
